// File: src/trmb_pkg.sv
`default_nettype none

package trmb_pkg;

    // Default sizing of the message ring.
    localparam int RING_BYTES_DEF        = 4096;
    localparam int MAX_PAYLOAD_BYTES_DEF = 32;
    localparam int MAX_ALIGN_DEF         = 4096;

    // Stream widths: input tdata holds tag, size, align and payload byte;
    // output tdata holds status, read byte, not-empty flag and head tag.
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 1;

    typedef enum logic [1:0] {
        CMD_POST_HDR  = 2'd0,
        CMD_POST_BYTE = 2'd1,
        CMD_READ      = 2'd2,
        CMD_TOSS      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_BAD_ARG    = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_OUT_OF_SEQ = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic hdr_step;
        logic fetch_start;
        logic fetch_step;
        logic stream_emit;
        logic resp_emit;
    } dp_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic do_hdr;
        logic hdr_last;
        logic need_fetch;
        logic fetch_done;
        logic streaming;
        logic stream_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: src/trmb_ram.sv
`default_nettype none

module trmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/trmb_ctrl.sv
`default_nettype none

module trmb_ctrl import trmb_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire dp_sts_t sts,
    output dp_ctl_t      ctl
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_WRHDR  = 8'b0000_0100,
        S_HEAD   = 8'b0000_1000,
        S_FETCH  = 8'b0001_0000,
        S_RDREQ  = 8'b0010_0000,
        S_RDDATA = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new beat is taken only while no command is in progress.
    assign s_tready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = sts.do_hdr ? S_WRHDR : S_HEAD;
            end
            S_WRHDR: begin
                ctl.hdr_step = 1'b1;
                if (sts.hdr_last) begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                if (sts.need_fetch) begin
                    ctl.fetch_start = 1'b1;
                    state_next      = S_FETCH;
                end else if (sts.streaming) begin
                    state_next = S_RDREQ;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_FETCH: begin
                ctl.fetch_step = 1'b1;
                if (sts.fetch_done) begin
                    state_next = S_HEAD;
                end
            end
            S_RDREQ: begin
                state_next = S_RDDATA;
            end
            S_RDDATA: begin
                if (sts.out_free) begin
                    ctl.stream_emit = 1'b1;
                    state_next      = sts.stream_last ? S_IDLE : S_RDREQ;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    ctl.resp_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/trmb_dp.sv
`default_nettype none

module trmb_dp import trmb_pkg::*; #(
    parameter int RING_BYTES        = RING_BYTES_DEF,
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
    parameter int MAX_ALIGN         = MAX_ALIGN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] in_data,
    input  wire logic [S_USER_W-1:0] in_user,
    input  wire dp_ctl_t             ctl,
    output dp_sts_t                  sts,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic      [M_USER_W-1:0] m_tuser,
    output logic                     m_tlast
);

    localparam int ADDR_W     = $clog2(RING_BYTES);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int CNT_W      = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int SUM_W      = ((PTR_W > 16) ? PTR_W : 16) + 1;
    localparam int HDR_BYTES  = 8;
    localparam logic [ADDR_W:0] RING_LIM  = (ADDR_W + 1)'(RING_BYTES);
    localparam logic [2:0]      HDR_LAST  = 3'(HDR_BYTES - 1);
    localparam logic [2:0]      FETCH_END = 3'd6;

    // Advance a ring offset (wrap bit over entry index) by less than one lap.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [ADDR_W-1:0] inc);
        logic [ADDR_W:0] sum;
        logic            wrap;
        sum  = {1'b0, p[ADDR_W-1:0]} + {1'b0, inc};
        wrap = p[PTR_W-1];
        if (sum >= RING_LIM) begin
            sum  = sum - RING_LIM;
            wrap = ~wrap;
        end
        return {wrap, sum[ADDR_W-1:0]};
    endfunction

    // Ring entry that lies a short distance past a given entry.
    function automatic logic [ADDR_W-1:0] idx_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] inc);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, inc};
        if (sum >= RING_LIM) begin
            sum = sum - RING_LIM;
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Latched input beat.
    cmd_t        cmd_reg;
    logic [15:0] tag_reg;
    logic [15:0] size_reg;
    logic [15:0] align_reg;
    logic [7:0]  pbyte_reg;

    // Ring offsets and the pending message.
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic             collecting_reg;
    logic [CNT_W-1:0] collected_reg;
    logic [CNT_W-1:0] pending_reg;

    // Cached header of the head message.
    logic        hvalid_reg;
    logic [15:0] htag_reg;
    logic [15:0] halign_reg;
    logic [15:0] hsize_reg;

    // Sequencing counters.
    logic [2:0]        hcnt_reg;
    logic [2:0]        fcnt_reg;
    logic              streaming_reg;
    logic [ADDR_W-1:0] sbase_reg;
    logic [CNT_W-1:0]  sidx_reg;
    logic [CNT_W-1:0]  scount_reg;
    status_t           status_reg;

    // Output register.
    logic        m_tvalid_reg;
    status_t     o_status_reg;
    logic [7:0]  o_byte_reg;
    logic        o_bvalid_reg;
    logic        o_last_reg;
    logic        o_ne_reg;
    logic [15:0] o_htag_reg;

    logic [PTR_W-1:0]  fill;
    logic              empty;
    logic              bad_post;
    logic              no_space;
    logic              rd_mismatch;
    status_t           verdict;
    logic              ok;
    logic              pay_done;
    logic              rd_adv;
    logic              out_load;
    logic              out_free;
    logic              stream_last;
    logic [7:0]        hdr_byte;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Fill level from the two offsets.
    always_comb begin
        if (wp_reg[PTR_W-1] == rp_reg[PTR_W-1]) begin
            fill = {1'b0, wp_reg[ADDR_W-1:0]} - {1'b0, rp_reg[ADDR_W-1:0]};
        end else begin
            fill = {1'b0, wp_reg[ADDR_W-1:0]} + RING_LIM - {1'b0, rp_reg[ADDR_W-1:0]};
        end
    end

    assign empty    = (wp_reg == rp_reg);
    assign bad_post = (size_reg > 16'(MAX_PAYLOAD_BYTES)) || (align_reg > 16'(MAX_ALIGN));
    assign no_space = (SUM_W'(fill) + SUM_W'(size_reg) + SUM_W'(HDR_BYTES))
                      >= SUM_W'(RING_BYTES);
    assign rd_mismatch = (htag_reg != tag_reg) || (hsize_reg != size_reg) ||
                         (halign_reg != align_reg) ||
                         (hsize_reg > 16'(MAX_PAYLOAD_BYTES));

    // Outcome of the latched command.
    always_comb begin
        unique case (cmd_reg)
            CMD_POST_HDR: begin
                if (collecting_reg) begin
                    verdict = ST_OUT_OF_SEQ;
                end else if (bad_post) begin
                    verdict = ST_BAD_ARG;
                end else if (no_space) begin
                    verdict = ST_NO_SPACE;
                end else begin
                    verdict = ST_OK;
                end
            end
            CMD_POST_BYTE: begin
                verdict = collecting_reg ? ST_OK : ST_OUT_OF_SEQ;
            end
            CMD_READ: begin
                if (empty) begin
                    verdict = ST_EMPTY;
                end else if (rd_mismatch) begin
                    verdict = ST_BAD_ARG;
                end else begin
                    verdict = ST_OK;
                end
            end
            CMD_TOSS: begin
                if (empty) begin
                    verdict = ST_EMPTY;
                end else if (htag_reg != tag_reg) begin
                    verdict = ST_BAD_ARG;
                end else begin
                    verdict = ST_OK;
                end
            end
            default: begin
                verdict = ST_OUT_OF_SEQ;
            end
        endcase
    end

    assign ok          = (verdict == ST_OK);
    assign pay_done    = (collected_reg + CNT_W'(1)) == pending_reg;
    assign rd_adv      = ctl.exec && ok && (cmd_reg == CMD_READ || cmd_reg == CMD_TOSS);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign out_load    = ctl.stream_emit || ctl.resp_emit;
    assign stream_last = (sidx_reg == scount_reg - CNT_W'(1));

    // Header byte for the current write step, little-endian fields.
    always_comb begin
        case (hcnt_reg)
            3'd0:    hdr_byte = tag_reg[7:0];
            3'd1:    hdr_byte = tag_reg[15:8];
            3'd2:    hdr_byte = align_reg[7:0];
            3'd3:    hdr_byte = align_reg[15:8];
            3'd4:    hdr_byte = size_reg[7:0];
            3'd5:    hdr_byte = size_reg[15:8];
            default: hdr_byte = 8'h00;
        endcase
    end

    // Ring memory ports.
    assign ram_we    = ctl.hdr_step || (ctl.exec && ok && cmd_reg == CMD_POST_BYTE);
    assign ram_waddr = ctl.hdr_step
        ? idx_add(wp_reg[ADDR_W-1:0], ADDR_W'(hcnt_reg))
        : idx_add(wp_reg[ADDR_W-1:0], ADDR_W'(HDR_BYTES) + ADDR_W'(collected_reg));
    assign ram_wdata = ctl.hdr_step ? hdr_byte : pbyte_reg;
    assign ram_raddr = ctl.fetch_step
        ? idx_add(rp_reg[ADDR_W-1:0], ADDR_W'(fcnt_reg))
        : idx_add(sbase_reg, ADDR_W'(sidx_reg));

    trmb_ram #(
        .WIDTH(8),
        .DEPTH(RING_BYTES)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Input beat capture.
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg   <= cmd_t'(in_user);
            tag_reg   <= in_data[15:0];
            size_reg  <= in_data[31:16];
            align_reg <= in_data[47:32];
            pbyte_reg <= in_data[55:48];
        end
    end

    // Write side: header steps, payload collection and commit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            collecting_reg <= 1'b0;
            collected_reg  <= '0;
            pending_reg    <= '0;
        end else if (ctl.hdr_step && hcnt_reg == HDR_LAST) begin
            if (size_reg == 16'd0) begin
                wp_reg <= ptr_add(wp_reg, ADDR_W'(HDR_BYTES));
            end else begin
                collecting_reg <= 1'b1;
                pending_reg    <= size_reg[CNT_W-1:0];
                collected_reg  <= '0;
            end
        end else if (ctl.exec && ok && cmd_reg == CMD_POST_BYTE) begin
            if (pay_done) begin
                wp_reg         <= ptr_add(wp_reg, ADDR_W'(HDR_BYTES) + ADDR_W'(pending_reg));
                collecting_reg <= 1'b0;
                collected_reg  <= '0;
                pending_reg    <= '0;
            end else begin
                collected_reg <= collected_reg + CNT_W'(1);
            end
        end
    end

    // Read side: head advance, header cache and payload streaming.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg        <= '0;
            hvalid_reg    <= 1'b0;
            streaming_reg <= 1'b0;
        end else begin
            if (rd_adv) begin
                rp_reg     <= ptr_add(rp_reg,
                                      ADDR_W'(HDR_BYTES) + ADDR_W'(hsize_reg[CNT_W-1:0]));
                hvalid_reg <= 1'b0;
                if (cmd_reg == CMD_READ && hsize_reg != 16'd0) begin
                    streaming_reg <= 1'b1;
                end
            end else if (ctl.fetch_step && fcnt_reg == FETCH_END) begin
                hvalid_reg <= 1'b1;
            end
            if (ctl.stream_emit && stream_last) begin
                streaming_reg <= 1'b0;
            end
        end
    end

    // Stream setup, counters and header capture.
    always_ff @(posedge aclk) begin
        if (rd_adv) begin
            sbase_reg  <= idx_add(rp_reg[ADDR_W-1:0], ADDR_W'(HDR_BYTES));
            scount_reg <= hsize_reg[CNT_W-1:0];
            sidx_reg   <= '0;
        end else if (ctl.stream_emit) begin
            sidx_reg <= sidx_reg + CNT_W'(1);
        end
        if (ctl.exec) begin
            status_reg <= verdict;
            hcnt_reg   <= '0;
        end else if (ctl.hdr_step) begin
            hcnt_reg <= hcnt_reg + 3'd1;
        end
        if (ctl.fetch_start) begin
            fcnt_reg <= '0;
        end else if (ctl.fetch_step) begin
            fcnt_reg <= fcnt_reg + 3'd1;
            case (fcnt_reg)
                3'd1:    htag_reg[7:0]    <= ram_rdata;
                3'd2:    htag_reg[15:8]   <= ram_rdata;
                3'd3:    halign_reg[7:0]  <= ram_rdata;
                3'd4:    halign_reg[15:8] <= ram_rdata;
                3'd5:    hsize_reg[7:0]   <= ram_rdata;
                3'd6:    hsize_reg[15:8]  <= ram_rdata;
                default: ;
            endcase
        end
    end

    // Output register, loaded only when the previous beat has gone.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_status_reg <= ctl.stream_emit ? ST_OK : status_reg;
            o_byte_reg   <= ctl.stream_emit ? ram_rdata : 8'h00;
            o_bvalid_reg <= ctl.stream_emit;
            o_last_reg   <= ctl.stream_emit ? stream_last : 1'b1;
            o_ne_reg     <= !empty;
            o_htag_reg   <= empty ? 16'h0000 : htag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, o_htag_reg, o_ne_reg, o_byte_reg, o_status_reg};
    assign m_tuser  = o_bvalid_reg;
    assign m_tlast  = o_last_reg;

    // Status back to the controller.
    always_comb begin
        sts             = '0;
        sts.do_hdr      = ok && (cmd_reg == CMD_POST_HDR);
        sts.hdr_last    = (hcnt_reg == HDR_LAST);
        sts.need_fetch  = !empty && !hvalid_reg;
        sts.fetch_done  = (fcnt_reg == FETCH_END);
        sts.streaming   = streaming_reg;
        sts.stream_last = stream_last;
        sts.out_free    = out_free;
    end

    // A command that finds a message waiting must see its header cached.
    a_head_cached: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.exec && !empty |-> hvalid_reg)
        else $error("head header not cached at command execution");

    // The cache never describes an empty box.
    a_cache_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        hvalid_reg |-> !empty)
        else $error("header cache valid while box is empty");

    // Fill never exceeds the ring.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill <= RING_LIM)
        else $error("fill level beyond ring size");

    // A pending message always has bytes still due.
    a_collect_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        collecting_reg |-> (collected_reg < pending_reg))
        else $error("payload count reached size while still collecting");

endmodule

`default_nettype wire

// File: src/tagged_message_ring_buffer.sv
// An accepted input beat is executed; a header post then writes its 8 header bytes, and a
// command that leaves a new head message fetches that header through the ring's single read
// port. The result beat, or each payload byte of a read, then goes out through the output
// register, which waits while the previous beat is still held. No new input beat is taken
// until the command is complete, including the last byte of a read.
// Reset: synchronous, active low; the box comes up empty with no pending post.
`default_nettype none

module tagged_message_ring_buffer import trmb_pkg::*; #(
    parameter int RING_BYTES        = RING_BYTES_DEF,
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
    parameter int MAX_ALIGN         = MAX_ALIGN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // msg_tag[15:0], msg_size[31:16], msg_align[47:32], payload_byte[55:48]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [S_USER_W-1:0] s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[2:0], read_byte[10:3], not_empty[11], head_tag[27:12], zero[31:28]
    output logic      [M_DATA_W-1:0] m_tdata,
    // byte_valid[0]
    output logic      [M_USER_W-1:0] m_tuser,
    output logic                     m_tlast
);

    dp_ctl_t ctl;
    dp_sts_t sts;

    // Command sequencer.
    trmb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // Ring memory, offsets, header cache and output register.
    trmb_dp #(
        .RING_BYTES       (RING_BYTES),
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
        .MAX_ALIGN        (MAX_ALIGN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_tdata),
        .in_user (s_tuser),
        .ctl     (ctl),
        .sts     (sts),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire

// File: bench/tagged_message_ring_buffer_tb.sv
`timescale 1ns / 1ps

module tagged_message_ring_buffer_tb import trmb_pkg::*; ();

    localparam int unsigned RING        = RING_BYTES_DEF;
    localparam int unsigned MAX_PAYLOAD = MAX_PAYLOAD_BYTES_DEF;
    localparam int unsigned MAX_ALIGN   = MAX_ALIGN_DEF;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned HOLD_CYCLES = 300;

    // One command beat as it goes onto the input stream.
    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] tag;
        logic [15:0] size;
        logic [15:0] align;
        logic [7:0]  pbyte;
        int unsigned id;
    } msg_cmd_t;

    // One result beat, tagged with the command that causes it.
    typedef struct packed {
        int unsigned owner;
        status_t     status;
        logic [7:0]  rbyte;
        logic        valid;
        logic        last;
        logic        not_empty;
        logic [15:0] head_tag;
    } reply_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    tagged_message_ring_buffer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the message box.
    logic [7:0]  ring_mem [0:RING-1];
    logic [12:0] wr_off;
    logic [12:0] rd_off;
    bit          filling;
    int unsigned bytes_in;
    int unsigned bytes_due;

    msg_cmd_t    cmd_backlog[$];
    reply_t      planned_replies[$];
    reply_t      awaited_replies[$];

    int unsigned next_id      = 0;
    int unsigned in_gap       = 0;
    int unsigned replies_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned next_hold_at = 150;
    bit          in_took      = 1'b0;
    bit          calm_in      = 1'b0;
    bit          calm_out     = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 8'hFF));
    endfunction

    // Mostly zero, sometimes a short gap, rarely a long one.
    function automatic int unsigned pick_gap(input int unsigned busy_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r >= busy_pct) return 0;
        if (r >= busy_pct / 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(0, 4));
        if (r < 85) return 16'($urandom_range(5, MAX_PAYLOAD - 1));
        return 16'(MAX_PAYLOAD);
    endfunction

    function automatic logic [15:0] pick_align();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, MAX_ALIGN));
        if (r < 85) return 16'(MAX_ALIGN);
        return 16'h0000;
    endfunction

    function automatic void ring_put(input int unsigned pos, input logic [7:0] v);
        ring_mem[pos % RING] = v;
    endfunction

    // Little-endian 16-bit word of the head message header.
    function automatic logic [15:0] head16(input int unsigned off);
        int unsigned p;
        p = rd_off + off;
        return {ring_mem[(p + 1) % RING], ring_mem[p % RING]};
    endfunction

    // Apply one command to the shadow box and queue the beats it causes.
    function automatic void ring_predict(input msg_cmd_t c);
        status_t     st;
        logic [12:0] fill;
        logic [12:0] base;
        logic [63:0] hdr;
        int unsigned left;
        int unsigned hsize;
        int unsigned beats;
        int unsigned i;
        bit          streams;
        reply_t      r;
        st      = ST_OK;
        beats   = 1;
        streams = 1'b0;
        base    = rd_off;
        fill    = wr_off - rd_off;
        hsize   = {head16(6), head16(4)};
        case (c.cmd)
            CMD_POST_HDR: begin
                if (filling) begin
                    st = ST_OUT_OF_SEQ;
                end else if (c.size > MAX_PAYLOAD || c.align > MAX_ALIGN) begin
                    st = ST_BAD_ARG;
                end else begin
                    left = (fill >= RING) ? 0 : RING - fill;
                    if (left == 0 || c.size + 8 >= left) begin
                        st = ST_NO_SPACE;
                    end else begin
                        hdr = {16'h0000, c.size, c.align, c.tag};
                        for (i = 0; i < 8; i++) ring_put(wr_off + i, hdr[8*i +: 8]);
                        if (c.size == 0) begin
                            wr_off = wr_off + 13'd8;
                        end else begin
                            filling   = 1'b1;
                            bytes_due = c.size;
                            bytes_in  = 0;
                        end
                    end
                end
            end
            CMD_POST_BYTE: begin
                if (!filling) begin
                    st = ST_OUT_OF_SEQ;
                end else begin
                    ring_put(wr_off + 8 + bytes_in, c.pbyte);
                    bytes_in++;
                    // The message becomes visible with its last payload byte.
                    if (bytes_in >= bytes_due) begin
                        wr_off    = 13'(wr_off + 8 + bytes_due);
                        filling   = 1'b0;
                        bytes_in  = 0;
                        bytes_due = 0;
                    end
                end
            end
            default: begin
                if (fill == 0) begin
                    st = ST_EMPTY;
                end else if (c.cmd == CMD_READ) begin
                    if (head16(0) != c.tag || hsize != c.size || head16(2) != c.align ||
                        hsize > MAX_PAYLOAD) begin
                        st = ST_BAD_ARG;
                    end else begin
                        streams = (hsize != 0);
                        if (streams) beats = hsize;
                        rd_off = 13'(rd_off + 8 + hsize);
                    end
                end else if (head16(0) != c.tag) begin
                    st = ST_BAD_ARG;
                end else begin
                    rd_off = 13'(rd_off + 8 + hsize);
                end
            end
        endcase

        // Every beat reports the head of the box after the command.
        r.owner     = c.id;
        r.status    = st;
        r.not_empty = (wr_off != rd_off);
        r.head_tag  = r.not_empty ? head16(0) : 16'h0000;
        for (i = 0; i < beats; i++) begin
            r.valid = streams;
            r.rbyte = streams ? ring_mem[(base + 8 + i) % RING] : 8'h00;
            r.last  = (i + 1 == beats);
            planned_replies.push_back(r);
        end
    endfunction

    task automatic send(input cmd_t op, input logic [15:0] tag, input logic [15:0] size,
                        input logic [15:0] align, input logic [7:0] pb);
        msg_cmd_t c;
        c.cmd   = op;
        c.tag   = tag;
        c.size  = size;
        c.align = align;
        c.pbyte = pb;
        c.id    = next_id;
        next_id++;
        cmd_backlog.push_back(c);
        ring_predict(c);
    endtask

    // Read or toss the head message with matching fields, or hit an empty box.
    task automatic serve_head(input bit toss);
        if (wr_off == rd_off)
            send(toss ? CMD_TOSS : CMD_READ, rnd16(), rnd16(), rnd16(), rnd8());
        else if (toss)
            send(CMD_TOSS, head16(0), rnd16(), rnd16(), rnd8());
        else
            send(CMD_READ, head16(0), head16(4), head16(2), rnd8());
    endtask

    // Header then payload; reads or tosses of older messages may slip in between bytes.
    task automatic post_msg(input logic [15:0] tag, input logic [15:0] size,
                            input logic [15:0] align, input bit mix_reads);
        send(CMD_POST_HDR, tag, size, align, rnd8());
        while (filling) begin
            if (mix_reads && $urandom_range(0, 99) < 8) serve_head(1'($urandom_range(0, 1)));
            send(CMD_POST_BYTE, rnd16(), rnd16(), rnd16(), rnd8());
        end
    endtask

    // Read or toss with one field of the head header flipped.
    task automatic skew_head();
        logic [15:0] flip;
        flip = 16'd1 << $urandom_range(0, 15);
        if (wr_off == rd_off) begin
            serve_head(1'b0);
        end else begin
            case ($urandom_range(0, 3))
                0: send(CMD_READ, head16(0) ^ flip, head16(4), head16(2), rnd8());
                1: send(CMD_READ, head16(0), head16(4) ^ flip, head16(2), rnd8());
                2: send(CMD_READ, head16(0), head16(4), head16(2) ^ flip, rnd8());
                default: send(CMD_TOSS, head16(0) ^ flip, rnd16(), rnd16(), rnd8());
            endcase
        end
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned first_id;
        int unsigned r;
        first_id = next_id;
        while (next_id - first_id < count) begin
            // Finish any message left open by a stray header.
            while (filling) send(CMD_POST_BYTE, rnd16(), rnd16(), rnd16(), rnd8());
            r = $urandom_range(0, 99);
            if (r < 40) begin
                post_msg(rnd16(), pick_size(), pick_align(), 1'b1);
            end else if (r < 62) begin
                serve_head(1'b0);
            end else if (r < 72) begin
                serve_head(1'b1);
            end else if (r < 79) begin
                skew_head();
            end else if (r < 86) begin
                if ($urandom_range(0, 1))
                    send(CMD_POST_HDR, rnd16(),
                         16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF)),
                         pick_align(), rnd8());
                else
                    send(CMD_POST_HDR, rnd16(), pick_size(),
                         16'($urandom_range(MAX_ALIGN + 1, 16'hFFFF)), rnd8());
            end else if (r < 91) begin
                // A second header while payload is still due.
                send(CMD_POST_HDR, rnd16(), 16'($urandom_range(1, MAX_PAYLOAD)),
                     pick_align(), rnd8());
                send(CMD_POST_HDR, rnd16(), pick_size(), pick_align(), rnd8());
            end else begin
                send(cmd_t'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16(), rnd8());
            end
        end
    endtask

    // Stimulus plan, reset and end of run.
    initial begin
        int unsigned k;
        for (k = 0; k < RING; k++) ring_mem[k] = 8'h00;
        wr_off    = '0;
        rd_off    = '0;
        filling   = 1'b0;
        bytes_in  = 0;
        bytes_due = 0;

        // Empty box, stray payload byte and rejected headers.
        serve_head(1'b0);
        serve_head(1'b1);
        send(CMD_POST_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
        send(CMD_POST_HDR, 16'hFFFF, 16'(MAX_PAYLOAD + 1), 16'h0000, 8'h00);
        send(CMD_POST_HDR, 16'hFFFF, 16'h0000, 16'(MAX_ALIGN + 1), 8'h00);
        send(CMD_POST_HDR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        // A zero-size message is visible at once and reads as one beat.
        send(CMD_POST_HDR, 16'hFFFF, 16'h0000, 16'(MAX_ALIGN), 8'h00);
        serve_head(1'b0);
        // Three-byte message, with a header arriving out of turn.
        send(CMD_POST_HDR, 16'h0000, 16'd3, 16'h0000, 8'h00);
        send(CMD_POST_HDR, 16'h1234, 16'd1, 16'd1, 8'h00);
        send(CMD_POST_BYTE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
        send(CMD_POST_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
        send(CMD_POST_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hA5);
        // Mismatched tag, size and align are refused.
        send(CMD_READ, 16'h0001, 16'd3, 16'h0000, 8'h00);
        send(CMD_READ, 16'h0000, 16'd2, 16'h0000, 8'h00);
        send(CMD_READ, 16'h0000, 16'd3, 16'h8000, 8'h00);
        send(CMD_TOSS, 16'h8000, 16'd3, 16'h0000, 8'h00);
        send(CMD_READ, 16'h0000, 16'd3, 16'h0000, 8'h00);
        post_msg(16'h5A5A, 16'd1, 16'h0FFF, 1'b0);
        post_msg(16'hC3C3, 16'd2, 16'h0800, 1'b0);
        serve_head(1'b1);
        serve_head(1'b0);
        serve_head(1'b0);

        random_traffic(135);
        random_traffic(135);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_backlog.size() != 0 || awaited_replies.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Input side: note the accepted beat and hand its results to the checker.
    always @(posedge aclk) begin : cmd_accept
        msg_cmd_t done;
        in_took = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            in_took = 1'b1;
            done = cmd_backlog.pop_front();
            while (planned_replies.size() != 0 && planned_replies[0].owner == done.id)
                awaited_replies.push_back(planned_replies.pop_front());
            if ($urandom_range(0, 59) == 0) calm_in = !calm_in;
            in_gap = calm_in ? 0 : pick_gap(40);
        end
    end

    // Input side: present the next beat, after a random gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_took) begin
            if (in_gap != 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_backlog[0].cmd;
                s_tdata  <= {cmd_backlog[0].pbyte, cmd_backlog[0].align,
                             cmd_backlog[0].size, cmd_backlog[0].tag};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, with a long hold-off now and then so the box backs up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (replies_seen >= next_hold_at) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 1000;
            end
            if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = calm_out ? 0 : pick_gap(30);
                m_tready <= (stall_left == 0);
            end
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) $display("[%0t] result beat %0d: %s", $time, replies_seen, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s is %0h, wanted %0h", name, got, want));
    endtask

    // Output side: compare each accepted beat with the oldest outstanding result.
    always @(posedge aclk) begin : reply_check
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
                report_mismatch("beat arrived with no result outstanding");
            end else begin
                want = awaited_replies.pop_front();
                check_field("status", m_tdata[2:0], want.status);
                check_field("read_byte", m_tdata[10:3], want.rbyte);
                check_field("byte_valid", m_tuser[0], want.valid);
                check_field("last", m_tlast, want.last);
                check_field("not_empty", m_tdata[11], want.not_empty);
                check_field("head_tag", m_tdata[27:12], want.head_tag);
                check_field("tdata padding", m_tdata[31:28], 16'h0000);
            end
        end
    end

    // Watchdog: a long stretch with no beat on either side means the block hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// File: filelist.f
src/trmb_pkg.sv
src/trmb_ram.sv
src/trmb_ctrl.sv
src/trmb_dp.sv
src/tagged_message_ring_buffer.sv
bench/tagged_message_ring_buffer_tb.sv
